// ===== rtl/pcmwp_pkg.sv =====
// Shared types and constants for the eight-channel PCM wave player.
package pcmwp_pkg;

	localparam int NUM_CHANNELS       = 8;
	localparam int STEP_FRACTION_BITS = 11;
	localparam int WAVE_ADDR_BITS     = 16;

	localparam int POS_W     = WAVE_ADDR_BITS + STEP_FRACTION_BITS;
	localparam int WAVE_SIZE = 1 << WAVE_ADDR_BITS;
	localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int ACC_W     = 24;
	localparam int SUM_W     = 18;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;

	// control byte bits
	localparam int CTRL_MASTER_BIT = 7;
	localparam int CTRL_SEL_BIT    = 6;

	localparam logic [7:0] LOOP_MARK = 8'hFF;

	// bus register addresses
	localparam logic [3:0] REG_NUM_CH = 4'd7;
	localparam logic [3:0] REG_CTRL   = 4'd7;
	localparam logic [3:0] REG_ENABLE = 4'd8;

	// per-channel register bytes
	localparam int REG_VOL      = 0;
	localparam int REG_PAN      = 1;
	localparam int REG_STEP_LO  = 2;
	localparam int REG_STEP_HI  = 3;
	localparam int REG_LOOP_LO  = 4;
	localparam int REG_LOOP_HI  = 5;
	localparam int REG_START_HI = 6;

	typedef enum logic [1:0] {
		OP_REG_WR  = 2'd0,
		OP_ADDR_RD = 2'd1,
		OP_WAVE_WR = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CH,
		ST_W1,
		ST_W2,
		ST_MAC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [6:0][7:0]    regs;
	} ch_row_t;

endpackage

// ===== rtl/eight_channel_pcm_wave_player_top.sv =====
// Eight-channel PCM wave player: the bus-operation sequencer with its channel and wave memories.
//
// s_axis carries one bus operation per transaction: tuser holds the operation (register
// write, address counter read, wave memory write, sample tick), tdata holds register
// address, data byte and wave offset. m_axis returns exactly one result per operation:
// the read byte and the saturated left and right mix (zero where the operation has none).
// Register and wave writes pass from accept through ST_DONE to the result register; an
// address read also passes through ST_CH. A sample tick visits the channels one by one
// through the channel memory: a disabled channel is reset to its start position; an enabled
// one reads its sample (after a loop marker, the one at the loop target) and adds it to the
// mix unless that is a marker too. One operation is processed at a time; the next is
// accepted once the previous result is in the output register.
// Reset clears registers, positions, bank, select and enable mask at once; wave memory
// content is undefined until written.
// While m_axis_tready is low the result holds and the block can accept and process one
// more operation, then waits until the output register frees.
module eight_channel_pcm_wave_player_top import pcmwp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [3:0] reg_address, [11:4] data, [23:12] wave_offset
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] read_data, [25:8] left_sum, [43:26] right_sum, [47:44] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	state_t state_q, state_d;

	// item latch
	op_t        op_q;
	logic [3:0] addr_q;
	logic [CH_W-1:0] ch_q;

	// global registers
	logic [2:0] sel_q;
	logic [3:0] bank_q;
	logic [7:0] ctrl_q;
	logic [7:0] en_mask_q;

	// channel memory
	ch_row_t                ch_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] ch_vld_q;
	ch_row_t                ch_rd_row_q;
	logic                   ch_rd_vld_q;
	ch_row_t                row_eff;
	logic                   ch_wr_en;
	logic [CH_W-1:0]        ch_wr_addr;
	logic [6:0]             ch_wr_byte_en;
	logic [7:0]             ch_wr_data;
	logic                   ch_wr_pos_en;
	logic [POS_W-1:0]       ch_wr_pos;
	logic                   ch_rd_en;
	logic [CH_W-1:0]        ch_rd_addr;

	// wave memory
	logic [7:0]                wave_mem [WAVE_SIZE];
	logic [7:0]                wave_rd_q;
	logic                      wv_wr_en;
	logic [WAVE_ADDR_BITS-1:0] wv_wr_addr;
	logic                      wv_rd_en;
	logic [WAVE_ADDR_BITS-1:0] wv_rd_addr;

	// channel datapath
	ch_row_t           row_q;
	logic [11:0]       ml_q, mr_q;
	logic [POS_W-1:0]  new_pos_q;
	logic [7:0]        sample_q;
	logic signed [ACC_W-1:0] acc_l_q, acc_r_q;
	logic [7:0]        rd_q;

	logic              m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic               in_acc;
	op_t                in_op;
	logic [3:0]         in_addr;
	logic [7:0]         in_data;
	logic [11:0]        in_off;
	logic [19:0]        bank_sum;
	logic               sel_ok;
	logic               rd_ch_ok;
	logic [NUM_CHANNELS-1:0] en_vec;
	logic               adv_ch;
	logic               last_ch;
	logic               out_free;
	logic [POS_W+7:0]   start_ext;
	logic [POS_W-1:0]   start_pos;
	logic [WAVE_ADDR_BITS-1:0] loop_tgt;
	logic [15:0]        step;
	logic [23:0]        rd_word;
	logic signed [8:0]  val_s;
	logic signed [21:0] prod_l, prod_r;

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi, lo;
		hi = ACC_W'((1 <<< (SUM_W - 1)) - 1);
		lo = -ACC_W'(1 <<< (SUM_W - 1));
		if (v > hi)
			return SUM_W'(hi);
		else if (v < lo)
			return SUM_W'(lo);
		else
			return SUM_W'(v);
	endfunction

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign in_op   = op_t'(s_axis_tuser);
	assign in_addr = s_axis_tdata[3:0];
	assign in_data = s_axis_tdata[11:4];
	assign in_off  = s_axis_tdata[23:12];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign bank_sum = {4'd0, bank_q, 12'd0} + {8'd0, in_off};
	assign sel_ok   = (int'(sel_q) < NUM_CHANNELS);
	assign rd_ch_ok = (int'(addr_q[3:1]) < NUM_CHANNELS);
	assign last_ch  = (ch_q == CH_W'(NUM_CHANNELS - 1));

	// unwritten rows read as the reset value
	assign row_eff   = ch_rd_vld_q ? ch_rd_row_q : '0;
	assign start_ext = (POS_W+8)'(row_eff.regs[REG_START_HI]) << (STEP_FRACTION_BITS + 8);
	assign start_pos = start_ext[POS_W-1:0];
	assign loop_tgt  = WAVE_ADDR_BITS'({row_q.regs[REG_LOOP_HI], row_q.regs[REG_LOOP_LO]});
	assign step      = {row_q.regs[REG_STEP_HI], row_q.regs[REG_STEP_LO]};
	assign rd_word   = 24'(row_eff.pos[POS_W-1:STEP_FRACTION_BITS]);

	// sign-magnitude sample
	assign val_s  = sample_q[7] ? -$signed({2'b00, sample_q[6:0]}) : $signed({1'b0, sample_q});
	assign prod_l = val_s * $signed({1'b0, ml_q});
	assign prod_r = val_s * $signed({1'b0, mr_q});

	// channels from 8 upward have no enable bit
	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			en_vec[i] = (i < 8) && ctrl_q[CTRL_MASTER_BIT] && !en_mask_q[i % 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		ch_wr_en      = 1'b0;
		ch_wr_addr    = ch_q;
		ch_wr_byte_en = '0;
		ch_wr_data    = in_data;
		ch_wr_pos_en  = 1'b0;
		ch_wr_pos     = new_pos_q;
		ch_rd_en      = 1'b0;
		ch_rd_addr    = ch_q;
		wv_wr_en      = 1'b0;
		wv_wr_addr    = bank_sum[WAVE_ADDR_BITS-1:0];
		wv_rd_en      = 1'b0;
		wv_rd_addr    = row_eff.pos[POS_W-1:STEP_FRACTION_BITS];
		adv_ch        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_op)
						OP_REG_WR: begin
							if (in_addr < REG_NUM_CH && sel_ok) begin
								ch_wr_en      = 1'b1;
								ch_wr_addr    = CH_W'(sel_q);
								ch_wr_byte_en = 7'd1 << in_addr[2:0];
							end
							state_d = ST_DONE;
						end
						OP_ADDR_RD: begin
							ch_rd_en   = 1'b1;
							ch_rd_addr = CH_W'(in_addr[3:1]);
							state_d    = ST_CH;
						end
						OP_WAVE_WR: begin
							wv_wr_en = 1'b1;
							state_d  = ST_DONE;
						end
						OP_TICK: begin
							ch_rd_en   = 1'b1;
							ch_rd_addr = '0;
							state_d    = ST_CH;
						end
					endcase
				end
			end
			ST_CH: begin
				if (op_q == OP_ADDR_RD) begin
					state_d = ST_DONE;
				end else if (!en_vec[ch_q]) begin
					ch_wr_en     = 1'b1;
					ch_wr_pos_en = 1'b1;
					ch_wr_pos    = start_pos;
					adv_ch       = 1'b1;
				end else begin
					wv_rd_en = 1'b1;
					state_d  = ST_W1;
				end
			end
			ST_W1: begin
				if (wave_rd_q == LOOP_MARK) begin
					wv_rd_en   = 1'b1;
					wv_rd_addr = loop_tgt;
					state_d    = ST_W2;
				end else begin
					state_d = ST_MAC;
				end
			end
			ST_W2: begin
				if (wave_rd_q == LOOP_MARK) begin
					// loop target is a marker too: silent this tick
					ch_wr_en     = 1'b1;
					ch_wr_pos_en = 1'b1;
					adv_ch       = 1'b1;
				end else begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				ch_wr_en     = 1'b1;
				ch_wr_pos_en = 1'b1;
				adv_ch       = 1'b1;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (adv_ch) begin
			if (last_ch) begin
				state_d = ST_DONE;
			end else begin
				ch_rd_en   = 1'b1;
				ch_rd_addr = ch_q + 1'b1;
				state_d    = ST_CH;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= OP_REG_WR;
			addr_q    <= '0;
			ch_q      <= '0;
			sel_q     <= '0;
			bank_q    <= '0;
			ctrl_q    <= '0;
			en_mask_q <= '0;
			ch_vld_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				op_q   <= in_op;
				addr_q <= in_addr;
				ch_q   <= '0;
				if (in_op == OP_REG_WR) begin
					if (in_addr == REG_CTRL) begin
						if (in_data[CTRL_SEL_BIT])
							sel_q <= in_data[2:0];
						else
							bank_q <= in_data[3:0];
						ctrl_q <= in_data;
					end else if (in_addr == REG_ENABLE) begin
						en_mask_q <= in_data;
					end
				end
			end
			if (adv_ch && !last_ch)
				ch_q <= ch_q + 1'b1;
			if (ch_wr_en)
				ch_vld_q[ch_wr_addr] <= 1'b1;
			if (state_q == ST_DONE && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	// channel row memory; a first write to a row zero-fills the rest
	always_ff @(posedge clk) begin
		if (ch_wr_en) begin
			for (int b = 0; b < 7; b++) begin
				if (ch_wr_byte_en[b])
					ch_mem[ch_wr_addr].regs[b] <= ch_wr_data;
				else if (!ch_vld_q[ch_wr_addr])
					ch_mem[ch_wr_addr].regs[b] <= '0;
			end
			if (ch_wr_pos_en)
				ch_mem[ch_wr_addr].pos <= ch_wr_pos;
			else if (!ch_vld_q[ch_wr_addr])
				ch_mem[ch_wr_addr].pos <= '0;
		end
		if (ch_rd_en) begin
			ch_rd_row_q <= ch_mem[ch_rd_addr];
			ch_rd_vld_q <= ch_vld_q[ch_rd_addr];
		end
	end

	// wave memory
	always_ff @(posedge clk) begin
		if (wv_wr_en)
			wave_mem[wv_wr_addr] <= in_data;
		if (wv_rd_en)
			wave_rd_q <= wave_mem[wv_rd_addr];
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
			rd_q    <= '0;
		end
		if (state_q == ST_CH) begin
			row_q <= row_eff;
			ml_q  <= row_eff.regs[REG_VOL] * row_eff.regs[REG_PAN][3:0];
			mr_q  <= row_eff.regs[REG_VOL] * row_eff.regs[REG_PAN][7:4];
			if (op_q == OP_ADDR_RD)
				rd_q <= !rd_ch_ok ? 8'd0 : (addr_q[0] ? rd_word[15:8] : rd_word[7:0]);
		end
		if (state_q == ST_W1) begin
			sample_q <= wave_rd_q;
			if (wave_rd_q == LOOP_MARK)
				new_pos_q <= {loop_tgt, {STEP_FRACTION_BITS{1'b0}}};
			else
				new_pos_q <= POS_W'(row_q.pos + POS_W'(step));
		end
		if (state_q == ST_W2)
			sample_q <= wave_rd_q;
		if (state_q == ST_MAC) begin
			acc_l_q <= acc_l_q + ACC_W'(prod_l >>> 5);
			acc_r_q <= acc_r_q + ACC_W'(prod_r >>> 5);
		end
		if (state_q == ST_DONE && out_free)
			m_data_q <= {4'd0, sat_sum(acc_r_q), sat_sum(acc_l_q), rd_q};
	end

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("input accepted while an operation is in flight");

	a_w2_after_w1: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_W2 |-> $past(state_q) == ST_W1)
		else $error("loop fetch without a marker fetch before it");

	a_reg_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ch_wr_byte_en != '0 |-> state_q == ST_IDLE && $onehot(ch_wr_byte_en))
		else $error("channel register write outside an accepted register write");

	a_pos_write_tick: assert property (@(posedge clk) disable iff (!arst_n)
		ch_wr_pos_en |-> op_q == OP_TICK && ch_wr_byte_en == '0)
		else $error("position writeback outside a sample tick");

	a_done_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> m_valid_q && state_q == ST_IDLE)
		else $error("finished operation did not reach the output register");
`endif

endmodule
